>>> rtl/tckd_pkg.sv
// Package: widths, constants, register indexes and sequencer states for the knapsack block.
package tckd_pkg;

    localparam int WEIGHT_CAP_DEF = 63;
    localparam int VOLUME_CAP_DEF = 63;

    localparam int DIM_W    = 6;
    localparam int PRICE_W  = 16;
    localparam int PRIO_W   = 8;
    localparam int FRAG_W   = 8;
    localparam int GAIN_W   = PRICE_W + 1;
    localparam int PROFIT_W = 32;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 6;

    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_LIMIT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_VOLUME_LIMIT = CFG_IDX_W'(1);

    localparam logic [DIM_W-1:0] LIMIT_RESET = DIM_W'(63);

    localparam logic [PROFIT_W-1:0] PROFIT_MAX = {PROFIT_W{1'b1}};

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SWEEP,
        ST_DRAIN,
        ST_FETCH,
        ST_RESULT
    } seq_state_t;

endpackage

>>> rtl/tckd_ifs.sv
// Interfaces: input item channel and result channel.
interface tckd_item_if;
    logic                         valid;
    logic                         ready;
    logic [tckd_pkg::DIM_W-1:0]   item_weight;
    logic [tckd_pkg::DIM_W-1:0]   item_volume;
    logic [tckd_pkg::PRICE_W-1:0] item_price;
    logic [tckd_pkg::PRIO_W-1:0]  item_priority;
    logic [tckd_pkg::FRAG_W-1:0]  item_fragility;
    logic                         last_item;

    modport source (
        output valid, item_weight, item_volume, item_price, item_priority,
               item_fragility, last_item,
        input  ready
    );
    modport sink (
        input  valid, item_weight, item_volume, item_price, item_priority,
               item_fragility, last_item,
        output ready
    );
endinterface

interface tckd_result_if;
    logic                          valid;
    logic                          ready;
    logic [tckd_pkg::PROFIT_W-1:0] best_profit;

    modport source (output valid, best_profit, input ready);
    modport sink (input valid, best_profit, output ready);
endinterface

>>> rtl/two_constraint_knapsack_dp.sv
// Top level: two-limit 0/1 knapsack solver with a cell-serial table sweep.
//
//  channel  dir  beat fields                                              handshake
//  item     in   item_weight item_volume item_price item_priority         valid/ready
//                item_fragility last_item
//  result   out  best_profit                                              valid/ready
//  cfg      in   cfg_index cfg_data                                       cfg_we
//
// Flow: an item with positive gain that fits sweeps every table cell, then drains the pipeline,
//   one table cell per cycle through the shared cell unit.
// An item with no gain or out of range is taken without a sweep.
// A last item adds the result read (FETCH, RESULT) and a clear pass over every table
//   cell; the same clear pass runs after reset.
// A result waiting on the output register stalls only the next last item.
module two_constraint_knapsack_dp #(
    parameter int WEIGHT_CAP = tckd_pkg::WEIGHT_CAP_DEF,
    parameter int VOLUME_CAP = tckd_pkg::VOLUME_CAP_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [tckd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tckd_pkg::CFG_DATA_W-1:0]  cfg_data,
    tckd_item_if.sink                        item,
    tckd_result_if.source                    result
);

    localparam int WB     = $clog2(WEIGHT_CAP + 1);
    localparam int VB     = $clog2(VOLUME_CAP + 1);
    localparam int ADDR_W = WB + VB;
    localparam logic [WB-1:0] W_TOP = WB'(WEIGHT_CAP);
    localparam logic [VB-1:0] V_TOP = VB'(VOLUME_CAP);

    tckd_pkg::seq_state_t state_reg, state_next;

    logic [WB-1:0] w_reg, w_next;
    logic [VB-1:0] v_reg, v_next;
    logic [WB-1:0] iw_reg, iw_next;
    logic [VB-1:0] iv_reg, iv_next;
    logic [tckd_pkg::GAIN_W-1:0] gain_reg, gain_next;
    logic last_reg, last_next;

    logic              p_en_reg, p_en_next;
    logic [ADDR_W-1:0] p_addr_reg;

    logic [tckd_pkg::DIM_W-1:0] weight_limit_reg, volume_limit_reg;

    logic                          res_valid_reg, res_valid_next;
    logic [tckd_pkg::PROFIT_W-1:0] best_profit_reg, best_profit_next;

    logic                          accept;
    logic                          gain_pos;
    logic                          in_range;
    logic                          do_sweep;
    logic                          walk_done;
    logic                          res_free;
    logic [tckd_pkg::GAIN_W-1:0]   gain_in;
    logic [WB-1:0]                 wl;
    logic [VB-1:0]                 vl;

    logic                          wr_en;
    logic [ADDR_W-1:0]             wr_addr;
    logic [tckd_pkg::PROFIT_W-1:0] wr_data;
    logic [ADDR_W-1:0]             rd_a_addr;
    logic [ADDR_W-1:0]             rd_b_addr;
    logic [tckd_pkg::PROFIT_W-1:0] rd_a_data;
    logic [tckd_pkg::PROFIT_W-1:0] rd_b_data;
    logic [tckd_pkg::PROFIT_W-1:0] cand;
    logic                          take;

    assign accept    = item.valid && item.ready;
    assign gain_pos  = ({1'b0, item.item_price} + tckd_pkg::GAIN_W'(item.item_priority))
                       > tckd_pkg::GAIN_W'(item.item_fragility);
    assign gain_in   = {1'b0, item.item_price} + tckd_pkg::GAIN_W'(item.item_priority)
                       - tckd_pkg::GAIN_W'(item.item_fragility);
    assign in_range  = (32'(item.item_weight) <= 32'(WEIGHT_CAP))
                    && (32'(item.item_volume) <= 32'(VOLUME_CAP));
    assign do_sweep  = gain_pos && in_range;
    assign walk_done = (w_reg == '0) && (v_reg == '0);
    assign res_free  = !res_valid_reg || result.ready;

    assign wl = (32'(weight_limit_reg) > 32'(WEIGHT_CAP)) ? W_TOP : WB'(weight_limit_reg);
    assign vl = (32'(volume_limit_reg) > 32'(VOLUME_CAP)) ? V_TOP : VB'(volume_limit_reg);

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tckd_pkg::ST_CLEAR:
            begin
                if (walk_done)
                begin
                    state_next = tckd_pkg::ST_IDLE;
                end
            end
            tckd_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    priority if (do_sweep)
                    begin
                        state_next = tckd_pkg::ST_SWEEP;
                    end
                    else if (item.last_item)
                    begin
                        state_next = tckd_pkg::ST_FETCH;
                    end
                    else
                    begin
                        state_next = tckd_pkg::ST_IDLE;
                    end
                end
            end
            tckd_pkg::ST_SWEEP:
            begin
                if (walk_done)
                begin
                    state_next = tckd_pkg::ST_DRAIN;
                end
            end
            tckd_pkg::ST_DRAIN:
            begin
                state_next = last_reg ? tckd_pkg::ST_FETCH : tckd_pkg::ST_IDLE;
            end
            tckd_pkg::ST_FETCH:
            begin
                state_next = tckd_pkg::ST_RESULT;
            end
            tckd_pkg::ST_RESULT:
            begin
                if (res_free)
                begin
                    state_next = tckd_pkg::ST_CLEAR;
                end
            end
            default:
            begin
                state_next = tckd_pkg::ST_CLEAR;
            end
        endcase
    end

    // sequencer outputs: handshake and memory ports
    always_comb
    begin
        item.ready = 1'b0;
        rd_a_addr  = {w_reg, v_reg};
        rd_b_addr  = {w_reg - iw_reg, v_reg - iv_reg};
        wr_en      = p_en_reg && take;
        wr_addr    = p_addr_reg;
        wr_data    = cand;
        unique case (state_reg)
            tckd_pkg::ST_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = {w_reg, v_reg};
                wr_data = '0;
            end
            tckd_pkg::ST_IDLE:
            begin
                item.ready = 1'b1;
            end
            // keep the limit cell on the read port while the result waits
            tckd_pkg::ST_FETCH,
            tckd_pkg::ST_RESULT:
            begin
                rd_a_addr = {wl, vl};
            end
            tckd_pkg::ST_SWEEP,
            tckd_pkg::ST_DRAIN:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // walk counters, item latch, pipeline stage, result register
    always_comb
    begin
        w_next           = w_reg;
        v_next           = v_reg;
        iw_next          = iw_reg;
        iv_next          = iv_reg;
        gain_next        = gain_reg;
        last_next        = last_reg;
        p_en_next        = 1'b0;
        res_valid_next   = res_valid_reg && !result.ready;
        best_profit_next = best_profit_reg;

        if (accept)
        begin
            iw_next   = WB'(item.item_weight);
            iv_next   = VB'(item.item_volume);
            gain_next = gain_in;
            last_next = item.last_item;
            w_next    = W_TOP;
            v_next    = V_TOP;
        end

        if (state_reg == tckd_pkg::ST_SWEEP)
        begin
            p_en_next = (w_reg >= iw_reg) && (v_reg >= iv_reg);
        end

        if ((state_reg == tckd_pkg::ST_SWEEP || state_reg == tckd_pkg::ST_CLEAR)
            && !walk_done)
        begin
            if (v_reg == '0)
            begin
                w_next = w_reg - WB'(1);
                v_next = V_TOP;
            end
            else
            begin
                v_next = v_reg - VB'(1);
            end
        end

        if (state_reg == tckd_pkg::ST_RESULT && res_free)
        begin
            res_valid_next   = 1'b1;
            best_profit_next = rd_a_data;
            w_next           = W_TOP;
            v_next           = V_TOP;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= tckd_pkg::ST_CLEAR;
            w_reg            <= W_TOP;
            v_reg            <= V_TOP;
            p_en_reg         <= 1'b0;
            last_reg         <= 1'b0;
            res_valid_reg    <= 1'b0;
            weight_limit_reg <= tckd_pkg::LIMIT_RESET;
            volume_limit_reg <= tckd_pkg::LIMIT_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            w_reg         <= w_next;
            v_reg         <= v_next;
            p_en_reg      <= p_en_next;
            last_reg      <= last_next;
            res_valid_reg <= res_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    tckd_pkg::REG_WEIGHT_LIMIT: weight_limit_reg <= cfg_data;
                    tckd_pkg::REG_VOLUME_LIMIT: volume_limit_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        iw_reg          <= iw_next;
        iv_reg          <= iv_next;
        gain_reg        <= gain_next;
        p_addr_reg      <= {w_reg, v_reg};
        best_profit_reg <= best_profit_next;
    end

    assign result.valid       = res_valid_reg;
    assign result.best_profit = best_profit_reg;

    tckd_cell_unit u_cell (
        .here_val (rd_a_data),
        .from_val (rd_b_data),
        .gain     (gain_reg),
        .cand     (cand),
        .take     (take)
    );

    tckd_table_mem #(
        .ADDR_W (ADDR_W)
    ) u_table (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_a_addr (rd_a_addr),
        .rd_a_data (rd_a_data),
        .rd_b_addr (rd_b_addr),
        .rd_b_data (rd_b_data)
    );

endmodule

>>> rtl/tckd_cell_unit.sv
// Shared cell update unit: saturating add of the gain and compare against the current cell.
module tckd_cell_unit (
    input  logic [tckd_pkg::PROFIT_W-1:0] here_val,
    input  logic [tckd_pkg::PROFIT_W-1:0] from_val,
    input  logic [tckd_pkg::GAIN_W-1:0]   gain,
    output logic [tckd_pkg::PROFIT_W-1:0] cand,
    output logic                          take
);

    logic [tckd_pkg::PROFIT_W:0] sum;

    always_comb
    begin
        sum  = {1'b0, from_val} + (tckd_pkg::PROFIT_W + 1)'(gain);
        cand = sum[tckd_pkg::PROFIT_W] ? tckd_pkg::PROFIT_MAX
                                        : sum[tckd_pkg::PROFIT_W-1:0];
        take = cand > here_val;
    end

endmodule

>>> rtl/tckd_table_mem.sv
// Profit table memory: one write port, two registered read ports.
module tckd_table_mem #(
    parameter int ADDR_W = 12
) (
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [ADDR_W-1:0]             wr_addr,
    input  logic [tckd_pkg::PROFIT_W-1:0] wr_data,
    input  logic [ADDR_W-1:0]             rd_a_addr,
    output logic [tckd_pkg::PROFIT_W-1:0] rd_a_data,
    input  logic [ADDR_W-1:0]             rd_b_addr,
    output logic [tckd_pkg::PROFIT_W-1:0] rd_b_data
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [tckd_pkg::PROFIT_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_a_data <= mem[rd_a_addr];
        rd_b_data <= mem[rd_b_addr];
    end

endmodule

>>> rtl/tckd_checker.sv
// Port checker for the knapsack block, bound to the top level.
module tckd_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          item_valid,
    input logic                          item_ready,
    input logic                          item_last,
    input logic                          res_valid,
    input logic                          res_ready,
    input logic [tckd_pkg::PROFIT_W-1:0] res_data
);

    // stalled result beat holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_data))
        else $error("result beat changed while stalled");

    // clear pass follows reset
    a_clear_after_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> !item_ready)
        else $error("item taken during clear pass");

    // last beat always starts a busy period
    a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && item_last |=> !item_ready)
        else $error("ready after last beat");

    // a result appears only out of a busy period
    a_res_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(!item_ready))
        else $error("result raised while idle");

endmodule

bind two_constraint_knapsack_dp tckd_checker u_tckd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item.valid),
    .item_ready (item.ready),
    .item_last  (item.last_item),
    .res_valid  (result.valid),
    .res_ready  (result.ready),
    .res_data   (result.best_profit)
);
